// ----- rtl/sha_pkg.sv -----
// Shared types, constants and round functions of the SHA-256 block hash.
package sha_pkg;

  typedef struct packed {
    logic [31:0] message_word;
    logic        end_of_message;
  } in_req_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } out_rsp_t;

  typedef struct packed {
    logic [31:0] word;
    logic        block_end;
    logic        emit;
  } q_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_ROUND,
    ST_ADD,
    ST_OUT
  } back_state_t;

  localparam int QDepth = 4;
  localparam int QAw = $clog2(QDepth);

  localparam logic [3:0] LAST_POS = 4'd15;
  localparam logic [5:0] LAST_ROUND = 6'd63;
  localparam logic [2:0] LAST_DIGEST = 3'd7;

  localparam logic [31:0] H_INIT [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] K_ROUND [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [31:0] big_sigma0(input logic [31:0] v);
    return {v[1:0], v[31:2]} ^ {v[12:0], v[31:13]} ^ {v[21:0], v[31:22]};
  endfunction

  function automatic logic [31:0] big_sigma1(input logic [31:0] v);
    return {v[5:0], v[31:6]} ^ {v[10:0], v[31:11]} ^ {v[24:0], v[31:25]};
  endfunction

  function automatic logic [31:0] small_sigma0(input logic [31:0] v);
    return {v[6:0], v[31:7]} ^ {v[17:0], v[31:18]} ^ {3'b000, v[31:3]};
  endfunction

  function automatic logic [31:0] small_sigma1(input logic [31:0] v);
    return {v[16:0], v[31:17]} ^ {v[18:0], v[31:19]} ^ {10'b0, v[31:10]};
  endfunction

endpackage

// ----- rtl/sha_front.sv -----
// Front end: accepts message words, tracks the word position and tags block ends.
module sha_front
  import sha_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  in_req_t   in_req,
  input  q_status_t q_stat,
  output logic      busy,
  output logic      q_push,
  output q_item_t   q_item
);

  logic [3:0] pos_r;
  logic       accept;

  assign busy   = q_stat.full;
  assign accept = start && !q_stat.full;
  assign q_push = accept;

  always_comb begin
    q_item.word      = in_req.message_word;
    q_item.block_end = (pos_r == LAST_POS);
    q_item.emit      = (pos_r == LAST_POS) && in_req.end_of_message;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else if (accept) begin
      pos_r <= pos_r + 4'd1;
    end
  end

endmodule

// ----- rtl/sha_queue.sv -----
// Short queue of tagged message words between the front end and the compression unit.
module sha_queue
  import sha_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  q_item_t   push_item,
  input  logic      pop,
  output q_item_t   pop_item,
  output q_status_t stat
);

  q_item_t          mem_r [QDepth];
  logic [QAw-1:0]   wr_ptr_r;
  logic [QAw-1:0]   rd_ptr_r;
  logic [QAw:0]     count_r;

  assign stat.full  = (count_r == (QAw+1)'(QDepth));
  assign stat.empty = (count_r == '0);
  assign pop_item   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + QAw'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + QAw'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + (QAw+1)'(1);
      end else if (pop && !push) begin
        count_r <= count_r - (QAw+1)'(1);
      end
    end
  end

endmodule

// ----- rtl/sha_back.sv -----
// Compression unit: schedule window, 64 rounds, hash update and digest output.
module sha_back
  import sha_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  q_status_t q_stat,
  input  q_item_t   q_item,
  output logic      q_pop,
  output logic      out_valid,
  output out_rsp_t  out_rsp
);

  back_state_t state_r;
  back_state_t state_nxt;
  logic [5:0]  round_r;
  logic [2:0]  idx_r;
  logic        emit_r;
  logic [31:0] w_r    [16];
  logic [31:0] v_r    [8];
  logic [31:0] hash_r [8];

  logic [31:0] t1;
  logic [31:0] t2;
  logic [31:0] ch;
  logic [31:0] maj;
  logic [31:0] w_new;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_LOAD: begin
        if (!q_stat.empty && q_item.block_end) begin
          state_nxt = ST_ROUND;
        end
      end
      ST_ROUND: begin
        if (round_r == LAST_ROUND) begin
          state_nxt = ST_ADD;
        end
      end
      ST_ADD: begin
        state_nxt = emit_r ? ST_OUT : ST_LOAD;
      end
      ST_OUT: begin
        if (idx_r == LAST_DIGEST) begin
          state_nxt = ST_LOAD;
        end
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

  always_comb begin
    q_pop               = (state_r == ST_LOAD) && !q_stat.empty;
    out_valid           = (state_r == ST_OUT);
    out_rsp.digest_word = hash_r[idx_r];
    out_rsp.word_index  = idx_r;
    out_rsp.last_word   = (idx_r == LAST_DIGEST);
  end

  always_comb begin
    ch    = (v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]);
    maj   = (v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]);
    t1    = v_r[7] + big_sigma1(v_r[4]) + ch + K_ROUND[round_r] + w_r[0];
    t2    = big_sigma0(v_r[0]) + maj;
    w_new = small_sigma1(w_r[14]) + w_r[9] + small_sigma0(w_r[1]) + w_r[0];
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      for (int i = 0; i < 15; i++) begin
        w_r[i] <= w_r[i+1];
      end
      w_r[15] <= q_item.word;
      if (q_item.block_end) begin
        for (int i = 0; i < 8; i++) begin
          v_r[i] <= hash_r[i];
        end
      end
    end else if (state_r == ST_ROUND) begin
      for (int i = 0; i < 15; i++) begin
        w_r[i] <= w_r[i+1];
      end
      w_r[15] <= w_new;
      v_r[7]  <= v_r[6];
      v_r[6]  <= v_r[5];
      v_r[5]  <= v_r[4];
      v_r[4]  <= v_r[3] + t1;
      v_r[3]  <= v_r[2];
      v_r[2]  <= v_r[1];
      v_r[1]  <= v_r[0];
      v_r[0]  <= t1 + t2;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
      round_r <= '0;
      idx_r   <= '0;
      emit_r  <= 1'b0;
      for (int i = 0; i < 8; i++) begin
        hash_r[i] <= H_INIT[i];
      end
    end else begin
      state_r <= state_nxt;
      unique case (state_r)
        ST_LOAD: begin
          if (q_pop && q_item.block_end) begin
            round_r <= '0;
            emit_r  <= q_item.emit;
          end
        end
        ST_ROUND: begin
          round_r <= round_r + 6'd1;
        end
        ST_ADD: begin
          idx_r <= '0;
          for (int i = 0; i < 8; i++) begin
            hash_r[i] <= hash_r[i] + v_r[i];
          end
        end
        ST_OUT: begin
          idx_r <= idx_r + 3'd1;
          if (idx_r == LAST_DIGEST) begin
            for (int i = 0; i < 8; i++) begin
              hash_r[i] <= H_INIT[i];
            end
          end
        end
        default: begin
          round_r <= '0;
        end
      endcase
    end
  end

  a_round_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ROUND && round_r == LAST_ROUND) |=> (state_r == ST_ADD))
    else $error("Compression did not finish after the last round.");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_stat.empty)
    else $error("Queue popped while empty.");

  a_digest_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_rsp.last_word) |=> !out_valid)
    else $error("Digest output ran past the eighth word.");

  a_hash_restored: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_rsp.last_word) |=> (hash_r[0] == H_INIT[0] && hash_r[7] == H_INIT[7]))
    else $error("Hash state not restored after the digest.");

  a_no_pop_in_rounds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ROUND) |-> !q_pop)
    else $error("Queue popped during the rounds.");

endmodule

// ----- rtl/sha256_block_hash_top.sv -----
// SHA-256 block hash top level: front end, word queue and compression unit.
// A request carries one 32-bit big-endian word of an already padded message and is
// taken on a clock edge where start is high and busy is low; sixteen words make a
// block, and end_of_message counts only on the sixteenth. Words enter a four-entry
// queue at one per cycle while it has room. The compression unit drains one word
// per cycle while the queue holds one, then runs one round per cycle; the block
// rate is set by the single round datapath, and the unit pops no words in the rounds.
// When a block closes a message, the eight digest words follow the hash update on
// consecutive cycles, each marked by out_valid for exactly one cycle, most
// significant first; the receiver must take them as they come. The hash state
// then returns to the initial values for the next message.
module sha256_block_hash_top
  import sha_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  input  in_req_t  in_req,
  output logic     busy,
  output logic     out_valid,
  output out_rsp_t out_rsp
);

  q_status_t q_stat;
  logic      q_push;
  logic      q_pop;
  q_item_t   q_push_item;
  q_item_t   q_pop_item;

  sha_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .in_req (in_req),
    .q_stat (q_stat),
    .busy   (busy),
    .q_push (q_push),
    .q_item (q_push_item)
  );

  sha_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_push_item),
    .pop       (q_pop),
    .pop_item  (q_pop_item),
    .stat      (q_stat)
  );

  sha_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_stat    (q_stat),
    .q_item    (q_pop_item),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_rsp   (out_rsp)
  );

endmodule

// ----- bench/tb_top.sv -----
// Self-checking testbench for the SHA-256 block hash against a local predictor.
`timescale 1ns / 1ps

module tb_top;
  import sha_pkg::*;

  localparam int IDLE_PCT = 24;
  localparam int WORD_TARGET = 420;
  localparam int STALL_LIMIT = 3000;
  localparam int DRAIN_CYCLES = 150;

  localparam logic [31:0] IV_WORDS [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] ROUND_KEYS [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     start = 1'b0;
  in_req_t  in_req = '0;
  logic     busy;
  logic     out_valid;
  out_rsp_t out_rsp;

  in_req_t    word_queue[$];
  out_rsp_t   digest_q[$];
  out_rsp_t   want;
  logic [31:0] chain_h [8];
  logic [31:0] sched_w [16];
  logic [3:0]  block_pos;
  int          err_count = 0;
  int          words_taken = 0;
  int          stall_cycles = 0;
  int          words_queued = 0;

  sha256_block_hash_top dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .in_req   (in_req),
    .busy     (busy),
    .out_valid(out_valid),
    .out_rsp  (out_rsp)
  );

  always #5 clk = ~clk;

  function automatic logic [31:0] ror32(input logic [31:0] v, input int n);
    return (v >> n) | (v << (32 - n));
  endfunction

  task automatic run_rounds();
    logic [31:0] a, b, c, d, e, f, g, h;
    logic [31:0] w, t1, t2, ch, mj, s0, s1;
    int t;
    a = chain_h[0]; b = chain_h[1]; c = chain_h[2]; d = chain_h[3];
    e = chain_h[4]; f = chain_h[5]; g = chain_h[6]; h = chain_h[7];
    for (t = 0; t < 64; t++) begin
      if (t < 16) begin
        w = sched_w[t];
      end else begin
        s0 = sched_w[4'(t - 15)];
        s1 = sched_w[4'(t - 2)];
        w = (ror32(s1, 17) ^ ror32(s1, 19) ^ (s1 >> 10)) + sched_w[4'(t - 7)]
          + (ror32(s0, 7) ^ ror32(s0, 18) ^ (s0 >> 3)) + sched_w[4'(t)];
        sched_w[4'(t)] = w;
      end
      ch = (e & f) ^ (~e & g);
      mj = (a & b) ^ (a & c) ^ (b & c);
      t1 = h + (ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25)) + ch + ROUND_KEYS[t] + w;
      t2 = (ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22)) + mj;
      h = g; g = f; f = e; e = d + t1;
      d = c; c = b; b = a; a = t1 + t2;
    end
    chain_h[0] += a; chain_h[1] += b; chain_h[2] += c; chain_h[3] += d;
    chain_h[4] += e; chain_h[5] += f; chain_h[6] += g; chain_h[7] += h;
  endtask

  task automatic absorb_word(input in_req_t r);
    int i;
    sched_w[block_pos] = r.message_word;
    if (block_pos == 4'd15) begin
      run_rounds();
      if (r.end_of_message) begin
        for (i = 0; i < 8; i++) begin
          digest_q.push_back(out_rsp_t'{digest_word: chain_h[i], word_index: 3'(i),
                                        last_word: (i == 7)});
        end
        chain_h = IV_WORDS;
      end
    end
    block_pos = block_pos + 4'd1;
  endtask

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    err_count++;
  endtask

  function automatic logic [31:0] pick_word();
    case ($urandom_range(9))
      0: return 32'h0000_0000;
      1: return 32'hffff_ffff;
      2: return 32'h8000_0000;
      default: return $urandom;
    endcase
  endfunction

  task automatic queue_block(input bit closes);
    int i;
    in_req_t r;
    for (i = 0; i < 16; i++) begin
      r.message_word = pick_word();
      r.end_of_message = (i == 15) ? closes : ($urandom_range(9) == 0);
      word_queue.push_back(r);
    end
    words_queued += 16;
  endtask

  initial begin
    chain_h = IV_WORDS;
    sched_w = '{default: '0};
    block_pos = '0;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        absorb_word(in_req);
        words_taken++;
      end
      if (!start || !busy) begin
        if (word_queue.size() > 0 &&
            ((words_taken >= 160 && words_taken < 260) ||
             $urandom_range(99) >= IDLE_PCT)) begin
          start <= 1'b1;
          in_req <= word_queue.pop_front();
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (digest_q.size() == 0) begin
        report_mismatch($sformatf("unexpected digest word %h index %0d last %0b",
                                  out_rsp.digest_word, out_rsp.word_index,
                                  out_rsp.last_word));
      end else begin
        want = digest_q.pop_front();
        if (out_rsp.digest_word !== want.digest_word ||
            out_rsp.word_index !== want.word_index ||
            out_rsp.last_word !== want.last_word) begin
          report_mismatch($sformatf("got %h/%0d/%0b, want %h/%0d/%0b",
                                    out_rsp.digest_word, out_rsp.word_index,
                                    out_rsp.last_word, want.digest_word,
                                    want.word_index, want.last_word));
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || out_valid) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    in_req_t r;
    int i;
    int nblk;
    // The padded message "abc", with a stray end mark on one inner word.
    for (i = 0; i < 16; i++) begin
      r.message_word = (i == 0) ? 32'h6162_6380 : (i == 15) ? 32'h0000_0018 : 32'h0;
      r.end_of_message = (i == 15) || (i == 7);
      word_queue.push_back(r);
    end
    words_queued = 16;
    while (words_queued < WORD_TARGET) begin
      nblk = $urandom_range(1, 3);
      for (i = 0; i < nblk; i++) begin
        queue_block(i == nblk - 1 && $urandom_range(9) != 0);
      end
    end
    queue_block(1'b1);

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    while (word_queue.size() > 0 || start) @(posedge clk);
    while (digest_q.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
